// ----- hw/rtl/sshm_pkg.sv -----
package sshm_pkg;

  // sub-wafers along v, one dead band between each neighboring pair
  localparam int NUM_WAFERS = 2;
  localparam int NUM_DEAD   = NUM_WAFERS - 1;
  localparam int DEAD_LANES = (NUM_DEAD > 0) ? NUM_DEAD : 1;

  // strip quotient and per-item divider widths
  localparam int QW     = 16;
  localparam int PW     = 31;
  localparam int DVD_W  = 34;
  localparam int DSR_W  = QW + PW;
  localparam int KP_W   = QW + PW;

  // dead band height division by the wafer count
  localparam int HW          = 35;
  localparam int H_STEPS     = 7;
  localparam int H_STAGES    = HW / H_STEPS;
  localparam int REM_W       = $clog2(NUM_WAFERS) + 1;

  typedef enum logic [3:0] {
    REG_STRIP_PITCH     = 4'd0,
    REG_FIRST_STRIP     = 4'd1,
    REG_U_LEFT          = 4'd2,
    REG_U_RIGHT         = 4'd3,
    REG_V_DOWN          = 4'd4,
    REG_V_UP            = 4'd5,
    REG_DEAD_WIDTH      = 4'd6,
    REG_WAFER_THICKNESS = 4'd7
  } cfg_reg_e;

  typedef logic signed [31:0] centre_t;

  typedef struct packed {
    logic [DVD_W-1:0] rem;
    logic [DSR_W-1:0] dsr;
    logic [QW-1:0]    quo;
  } div_t;

  typedef struct packed {
    logic             u_in;
    logic             v_in;
    logic             u_ge_right;
    logic             margin;
    logic             tolin;
    logic             zok;
    logic             k_low;
    logic [QW-1:0]    k;
    logic [KP_W-1:0]  kp;
    logic signed [31:0] v;
    logic [30:0]      tol;
  } side_t;

endpackage

// ----- hw/rtl/strip_sensor_hit_mapper_core.sv -----
// an accepted input item passes the capture, front, divider and output registers to become its result item
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// the per-item strip quotient comes from a 17-stage restoring divider: an overflow check, then one bit a stage
// dead band centres follow register writes through a free-running pipeline
// reset (rst, synchronous): configuration registers to their defaults, all stage valid bits cleared
module strip_sensor_hit_mapper_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] u,
  input  logic signed [31:0] v,
  input  logic signed [31:0] z_local,
  input  logic [30:0]        tolerance,
  input  logic [15:0]        strip_query,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               strip_valid,
  output logic [15:0]        strip_at_point,
  output logic [15:0]        nearest_strip,
  output logic               inside_margin,
  output logic               inside_tolerance,
  output logic               inside_detailed,
  output logic               in_dead_zone,
  output logic signed [31:0] strip_u
);

  localparam int NDIV = sshm_pkg::QW;

  // configuration registers
  logic [30:0]        strip_pitch;
  logic [15:0]        first_strip;
  logic signed [31:0] u_left;
  logic signed [31:0] u_right;
  logic signed [31:0] v_down;
  logic signed [31:0] v_up;
  logic [30:0]        dead_width;
  logic [30:0]        wafer_thickness;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_pitch     <= 31'd65536;
      first_strip     <= '0;
      u_left          <= '0;
      u_right         <= '0;
      v_down          <= '0;
      v_up            <= '0;
      dead_width      <= '0;
      wafer_thickness <= '0;
    end else if (cfg_write) begin
      unique case (sshm_pkg::cfg_reg_e'(cfg_index))
        sshm_pkg::REG_STRIP_PITCH:     strip_pitch     <= cfg_data[30:0];
        sshm_pkg::REG_FIRST_STRIP:     first_strip     <= cfg_data[15:0];
        sshm_pkg::REG_U_LEFT:          u_left          <= cfg_data;
        sshm_pkg::REG_U_RIGHT:         u_right         <= cfg_data;
        sshm_pkg::REG_V_DOWN:          v_down          <= cfg_data;
        sshm_pkg::REG_V_UP:            v_up            <= cfg_data;
        sshm_pkg::REG_DEAD_WIDTH:      dead_width      <= cfg_data[30:0];
        sshm_pkg::REG_WAFER_THICKNESS: wafer_thickness <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // a pitch of zero acts as one lsb
  logic [30:0] p_used;
  assign p_used = (strip_pitch == '0) ? 31'd1 : strip_pitch;

  // dead band centres, settled long before an item reaches the final stage
  sshm_pkg::centre_t [sshm_pkg::DEAD_LANES-1:0] centres;

  sshm_cfg_derive u_derive (
    .clk        (clk),
    .v_down     (v_down),
    .v_up       (v_up),
    .dead_width (dead_width),
    .centres    (centres)
  );

  // the whole pipeline moves unless a finished result is held back
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input capture stage
  logic               a_valid;
  logic signed [31:0] a_u;
  logic signed [31:0] a_v;
  logic signed [31:0] a_z;
  logic [30:0]        a_tol;
  logic [15:0]        a_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_u   <= u;
      a_v   <= v;
      a_z   <= z_local;
      a_tol <= tolerance;
      a_q   <= strip_query;
    end
  end

  // front stage: edge compares, divider operand, strip offset product
  sshm_pkg::side_t f_side_next;
  logic [sshm_pkg::DVD_W-1:0] f_dvd_next;
  logic signed [33:0] ux, ul, ur, vx, vd, vu, zx, pw, tw, span, zabs, udiff;
  logic [16:0]        kd;

  always_comb begin
    ux   = 34'(a_u);
    ul   = 34'(u_left);
    ur   = 34'(u_right);
    vx   = 34'(a_v);
    vd   = 34'(v_down);
    vu   = 34'(v_up);
    zx   = 34'(a_z);
    pw   = $signed({3'b000, p_used});
    tw   = $signed({3'b000, a_tol});
    span = ur - ul;
    udiff = ux - ul;
    zabs = zx[33] ? -zx : zx;
    kd   = {1'b0, a_q} - {1'b0, first_strip};

    f_side_next.u_in       = (a_u < u_right) && (a_u > u_left);
    f_side_next.v_in       = (a_v < v_up) && (a_v > v_down);
    f_side_next.u_ge_right = a_u >= u_right;
    // half-pitch margin compared at twice the scale
    f_side_next.margin     = ((ux <<< 1) < ((ur <<< 1) + pw))
                           && ((ux <<< 1) > ((ul <<< 1) - pw))
                           && f_side_next.v_in;
    f_side_next.tolin      = (ux < ur + tw) && (ux > ul - tw)
                           && (vx < vu + tw) && (vx > vd - tw);
    f_side_next.zok        = (zabs <<< 1) < $signed({3'b000, wafer_thickness});
    f_side_next.k_low      = !kd[16];
    f_side_next.k          = kd[15:0];
    f_side_next.kp         = sshm_pkg::KP_W'(kd[15:0]) * sshm_pkg::KP_W'(p_used);
    f_side_next.v          = a_v;
    f_side_next.tol        = a_tol;

    // inside in u the divider gives the strip, past the right edge the count
    if (f_side_next.u_in) begin
      f_dvd_next = udiff;
    end else if (span > 34'sd0) begin
      f_dvd_next = span;
    end else begin
      f_dvd_next = '0;
    end
  end

  logic                       f_valid;
  sshm_pkg::side_t            f_side;
  logic [sshm_pkg::DVD_W-1:0] f_dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side <= f_side_next;
      f_dvd  <= f_dvd_next;
    end
  end

  // divider: overflow check, then one quotient bit per stage
  logic            d_valid [NDIV+1];
  sshm_pkg::side_t d_side  [NDIV+1];
  sshm_pkg::div_t  d_div   [NDIV+1];
  logic            d_ovf   [NDIV+1];
  sshm_pkg::div_t  d_step  [NDIV];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (adv) begin
      d_valid[0] <= f_valid;
    end
  end

  // quotient of 65536 or more saturates the strip number
  always_ff @(posedge clk) begin
    if (adv) begin
      d_side[0]    <= f_side;
      d_ovf[0]     <= sshm_pkg::DSR_W'(f_dvd) >= {p_used, 16'd0};
      d_div[0].rem <= f_dvd;
      d_div[0].dsr <= sshm_pkg::DSR_W'({p_used, 15'd0});
      d_div[0].quo <= '0;
    end
  end

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    sshm_div_step u_step (
      .d_in  (d_div[i]),
      .d_out (d_step[i])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[i+1] <= 1'b0;
      end else if (adv) begin
        d_valid[i+1] <= d_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_side[i+1] <= d_side[i];
        d_ovf[i+1]  <= d_ovf[i];
        d_div[i+1]  <= d_step[i];
      end
    end
  end

  // final stage: strip numbers, queried strip position, dead band tests
  sshm_pkg::side_t    fs;
  logic [15:0]        quo_sat;
  logic [16:0]        sum_fq;
  logic [15:0]        sat_fq;
  logic signed [17:0] last_s;
  logic [15:0]        last_sat;
  logic [15:0]        at_next;
  logic [15:0]        near_next;
  logic [sshm_pkg::KP_W:0] kpp;
  logic signed [48:0] su_sum;
  logic signed [48:0] span49;
  logic               in_rng;
  logic signed [31:0] su_next;
  logic               hit_core;
  logic               hit_edge;
  logic               det_next;
  logic               dead_next;

  always_comb begin
    logic signed [34:0] c;
    logic signed [34:0] dw;
    logic signed [34:0] d0, d1, d2;
    fs       = d_side[NDIV];
    quo_sat  = d_ovf[NDIV] ? 16'hffff : d_div[NDIV].quo;
    sum_fq   = {1'b0, first_strip} + {1'b0, quo_sat};
    sat_fq   = sum_fq[16] ? 16'hffff : sum_fq[15:0];
    // last strip of the sensor, may fall to first_strip - 1 with no strips
    last_s   = $signed({2'b00, first_strip}) + $signed({2'b00, quo_sat}) - 18'sd1;
    if (last_s < 18'sd0) begin
      last_sat = '0;
    end else if (last_s > 18'sd65535) begin
      last_sat = 16'hffff;
    end else begin
      last_sat = last_s[15:0];
    end

    at_next = (fs.u_in && fs.v_in) ? sat_fq : 16'd0;
    priority if (fs.u_in) begin
      near_next = sat_fq;
    end else if (fs.u_ge_right) begin
      near_next = last_sat;
    end else begin
      near_next = first_strip;
    end

    // query in range when it is not below first_strip, k is not 0xffff and (k+1)*pitch still fits the span
    kpp    = (sshm_pkg::KP_W+1)'(fs.kp) + (sshm_pkg::KP_W+1)'(p_used);
    span49 = 49'(34'(u_right) - 34'(u_left));
    in_rng = fs.k_low && (fs.k != 16'hffff) && ($signed({1'b0, kpp}) <= span49);
    su_sum = 49'(u_left) + $signed({2'b00, fs.kp});
    if (!in_rng) begin
      su_next = '0;
    end else if (su_sum > 49'sd2147483647) begin
      su_next = 32'sh7fffffff;
    end else begin
      su_next = su_sum[31:0];
    end

    hit_core = 1'b0;
    hit_edge = 1'b0;
    dw = $signed({4'b0000, dead_width});
    for (int j = 0; j < sshm_pkg::NUM_DEAD; j++) begin
      c  = 35'(centres[j]);
      d0 = 35'(fs.v) - c;
      d1 = 35'(fs.v) + $signed({4'b0000, fs.tol}) - c;
      d2 = 35'(fs.v) - $signed({4'b0000, fs.tol}) - c;
      if ((d0[34] ? -d0 : d0) < dw) begin
        hit_core = 1'b1;
      end
      if (((d1[34] ? -d1 : d1) < dw) || ((d2[34] ? -d2 : d2) < dw)) begin
        hit_edge = 1'b1;
      end
    end
    det_next  = fs.margin && !(fs.zok && hit_core);
    dead_next = fs.tolin && hit_edge;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      strip_valid      <= fs.u_in && fs.v_in;
      strip_at_point   <= at_next;
      nearest_strip    <= near_next;
      inside_margin    <= fs.margin;
      inside_tolerance <= fs.tolin;
      inside_detailed  <= det_next;
      in_dead_zone     <= dead_next;
      strip_u          <= su_next;
    end
  end

endmodule

// ----- hw/rtl/sshm_div_step.sv -----
module sshm_div_step (
  input  sshm_pkg::div_t d_in,
  output sshm_pkg::div_t d_out
);

  logic [sshm_pkg::DSR_W-1:0] rem_x;
  logic [sshm_pkg::DSR_W-1:0] diff;
  logic                       ge;

  // one restoring quotient bit
  always_comb begin
    rem_x = sshm_pkg::DSR_W'(d_in.rem);
    ge    = rem_x >= d_in.dsr;
    diff  = rem_x - d_in.dsr;
    d_out.rem = ge ? diff[sshm_pkg::DVD_W-1:0] : d_in.rem;
    d_out.dsr = d_in.dsr >> 1;
    d_out.quo = {d_in.quo[sshm_pkg::QW-2:0], ge};
  end

endmodule

// ----- hw/rtl/sshm_cfg_derive.sv -----
module sshm_cfg_derive (
  input  logic                                   clk,
  input  logic signed [31:0]                     v_down,
  input  logic signed [31:0]                     v_up,
  input  logic [30:0]                            dead_width,
  output sshm_pkg::centre_t [sshm_pkg::DEAD_LANES-1:0] centres
);

  logic signed [32:0] vdiff;
  logic [32:0]        vabs;
  logic [sshm_pkg::HW-1:0] h_reg;
  logic signed [33:0]      base_reg;

  logic [sshm_pkg::HW-1:0]    dq     [sshm_pkg::H_STAGES+1];
  logic [sshm_pkg::REM_W-1:0] rem    [sshm_pkg::H_STAGES+1];
  logic signed [33:0]         base_s [sshm_pkg::H_STAGES+1];
  logic [sshm_pkg::HW-1:0]    dq_next  [sshm_pkg::H_STAGES];
  logic [sshm_pkg::REM_W-1:0] rem_next [sshm_pkg::H_STAGES];

  // height of the sensor plus both dead halves, and the lower reference
  always_comb begin
    vdiff = 33'(v_up) - 33'(v_down);
    vabs  = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
  end

  always_ff @(posedge clk) begin
    h_reg    <= sshm_pkg::HW'(vabs) + sshm_pkg::HW'({dead_width, 1'b0});
    base_reg <= 34'(v_down) - $signed({3'b000, dead_width});
  end

  assign dq[0]     = h_reg;
  assign rem[0]    = '0;
  assign base_s[0] = base_reg;

  // long division of the height by the wafer count, seven bits a stage
  for (genvar s = 0; s < sshm_pkg::H_STAGES; s++) begin : g_hdiv
    always_comb begin
      logic [sshm_pkg::REM_W:0]   t;
      logic [sshm_pkg::HW-1:0]    d;
      logic [sshm_pkg::REM_W-1:0] r;
      logic                       ge;
      d = dq[s];
      r = rem[s];
      for (int i = 0; i < sshm_pkg::H_STEPS; i++) begin
        t  = {r, d[sshm_pkg::HW-1]};
        ge = t >= (sshm_pkg::REM_W+1)'(sshm_pkg::NUM_WAFERS);
        if (ge) begin
          t = t - (sshm_pkg::REM_W+1)'(sshm_pkg::NUM_WAFERS);
        end
        r = t[sshm_pkg::REM_W-1:0];
        d = {d[sshm_pkg::HW-2:0], ge};
      end
      dq_next[s]  = d;
      rem_next[s] = r;
    end

    always_ff @(posedge clk) begin
      dq[s+1]     <= dq_next[s];
      rem[s+1]    <= rem_next[s];
      base_s[s+1] <= base_s[s];
    end
  end

  // centre j = base + (j+1)*quotient + floor((j+1)*remainder / wafers), saturated to 32 bits
  for (genvar j = 0; j < sshm_pkg::DEAD_LANES; j++) begin : g_lane
    logic signed [40:0] csum;
    always_comb begin
      logic [7:0] jr;
      logic [3:0] frac;
      jr   = 8'(j + 1) * 8'(rem[sshm_pkg::H_STAGES]);
      frac = '0;
      for (int t = 1; t < sshm_pkg::NUM_WAFERS; t++) begin
        if (8'(t * sshm_pkg::NUM_WAFERS) <= jr) begin
          frac = frac + 4'd1;
        end
      end
      csum = 41'(base_s[sshm_pkg::H_STAGES])
           + $signed({1'b0, 40'(dq[sshm_pkg::H_STAGES]) * 40'(j + 1)})
           + $signed({37'd0, frac});
    end

    always_ff @(posedge clk) begin
      if (csum > 41'sd2147483647) begin
        centres[j] <= 32'sh7fffffff;
      end else if (csum < -41'sd2147483648) begin
        centres[j] <= 32'sh80000000;
      end else begin
        centres[j] <= csum[31:0];
      end
    end
  end

endmodule
